>>> hw/rtl/rau_pkg.sv
// shared constants, codes and command types for the rational arithmetic unit
`default_nettype none
package rau_pkg;

  localparam int IN_W   = 72;
  localparam int OUT_W  = 72;
  localparam int RES_W  = 33;
  localparam int FIELD_W = 16;
  localparam int FUNC_W = 4;

  localparam logic [FUNC_W-1:0] FN_ADD = 4'd0;
  localparam logic [FUNC_W-1:0] FN_SUB = 4'd1;
  localparam logic [FUNC_W-1:0] FN_MUL = 4'd2;
  localparam logic [FUNC_W-1:0] FN_DIV = 4'd3;
  localparam logic [FUNC_W-1:0] FN_EQ  = 4'd4;
  localparam logic [FUNC_W-1:0] FN_GT  = 4'd5;
  localparam logic [FUNC_W-1:0] FN_LT  = 4'd6;
  localparam logic [FUNC_W-1:0] FN_GE  = 4'd7;
  localparam logic [FUNC_W-1:0] FN_LE  = 4'd8;

  localparam logic [1:0] MUL_LHS = 2'd0;
  localparam logic [1:0] MUL_RHS = 2'd1;
  localparam logic [1:0] MUL_DD  = 2'd2;
  localparam logic [1:0] MUL_NN  = 2'd3;

  localparam logic [1:0] ND_ARITH = 2'd0;
  localparam logic [1:0] ND_OPA   = 2'd1;
  localparam logic [1:0] ND_OPB   = 2'd2;

  localparam logic [1:0] DIV_XY = 2'd0;
  localparam logic [1:0] DIV_NG = 2'd1;
  localparam logic [1:0] DIV_DG = 2'd2;

  typedef struct packed {
    logic              load;
    logic [FUNC_W-1:0] func;
    logic              mul_en;
    logic [1:0]        mul_sel;
    logic              nd_en;
    logic [1:0]        nd_sel;
    logic              zero_res;
    logic              gcd_init;
    logic              gcd_step;
    logic              div_start;
    logic [1:0]        div_sel;
    logic              rn_en;
    logic              rd_en;
    logic              save_a;
    logic              err;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic d_zero;
    logic y_zero;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/rau_div.sv
// iterative signed divider, truncating quotient and remainder, one bit per cycle
`default_nettype none
module rau_div #(
  parameter int XW = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [XW-1:0] dividend,
  input  logic signed [XW-1:0] divisor,
  output logic                 done,
  output logic signed [XW-1:0] quo,
  output logic signed [XW-1:0] rem
);
  localparam int CW = $clog2(XW + 1);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [XW-1:0] quo_r, rem_r, bmag_r;
  logic          neg_q_r, neg_r_r;
  logic [XW-1:0] amag, bmag;
  logic [XW:0]   trial, diff;
  logic          ge;

  assign amag  = dividend[XW-1] ? (~dividend + 1'b1) : dividend;
  assign bmag  = divisor[XW-1] ? (~divisor + 1'b1) : divisor;
  assign trial = {rem_r, quo_r[XW-1]};
  assign diff  = trial - {1'b0, bmag_r};
  assign ge    = trial >= {1'b0, bmag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(XW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r   <= amag;
      rem_r   <= '0;
      bmag_r  <= bmag;
      neg_q_r <= dividend[XW-1] ^ divisor[XW-1];
      neg_r_r <= dividend[XW-1];
    end else if (busy_r) begin
      quo_r <= {quo_r[XW-2:0], ge};
      rem_r <= ge ? diff[XW-1:0] : trial[XW-1:0];
    end
  end

  assign done = done_r;
  assign quo  = $signed(neg_q_r ? (~quo_r + 1'b1) : quo_r);
  assign rem  = $signed(neg_r_r ? (~rem_r + 1'b1) : rem_r);

endmodule
`default_nettype wire

>>> hw/rtl/rau_dp.sv
// datapath: operand registers, shared multiplier, reduction registers and result register
`default_nettype none
module rau_dp #(
  parameter int W = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rau_pkg::cmd_t             cmd,
  input  logic [rau_pkg::IN_W-1:0]  in_data,
  output rau_pkg::sts_t             sts,
  output logic [rau_pkg::OUT_W-1:0] out_data
);
  import rau_pkg::*;

  localparam int PW = 2 * W;
  localparam int XW = 2 * W + 1;

  logic signed [W-1:0]  an_r, ad_r, bn_r, bd_r;
  logic signed [PW-1:0] lhs_r, rhs_r, dd_r, nn_r;
  logic signed [XW-1:0] n_r, d_r, x_r, y_r, rn_r, rd_r, an_red_r, ad_red_r;
  logic [OUT_W-1:0]     out_r;

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [XW-1:0] nc, dc, div_a, div_b, quo, rem;
  logic                 flip, div_done, cmp;
  logic [RES_W-1:0]     res_num, res_den;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      an_r <= W'(in_data[FUNC_W +: FIELD_W]);
      ad_r <= W'(in_data[FUNC_W + FIELD_W +: FIELD_W]);
      bn_r <= W'(in_data[FUNC_W + 2*FIELD_W +: FIELD_W]);
      bd_r <= W'(in_data[FUNC_W + 3*FIELD_W +: FIELD_W]);
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_LHS: begin mul_a = an_r; mul_b = bd_r; end
      MUL_RHS: begin mul_a = ad_r; mul_b = bn_r; end
      MUL_DD:  begin mul_a = ad_r; mul_b = bd_r; end
      default: begin mul_a = an_r; mul_b = bn_r; end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_LHS: lhs_r <= prod;
        MUL_RHS: rhs_r <= prod;
        MUL_DD:  dd_r  <= prod;
        default: nn_r  <= prod;
      endcase
    end
  end

  always_comb begin
    case (cmd.nd_sel)
      ND_ARITH: begin
        case (cmd.func)
          FN_ADD:  nc = XW'(lhs_r) + XW'(rhs_r);
          FN_SUB:  nc = XW'(lhs_r) - XW'(rhs_r);
          FN_MUL:  nc = XW'(nn_r);
          default: nc = XW'(lhs_r);
        endcase
        dc = (cmd.func == FN_DIV) ? XW'(rhs_r) : XW'(dd_r);
      end
      ND_OPB: begin
        nc = XW'(bn_r);
        dc = XW'(bd_r);
      end
      default: begin
        nc = XW'(an_r);
        dc = XW'(ad_r);
      end
    endcase
  end

  assign flip = (nc > 0) && (dc < 0);

  always_comb begin
    case (cmd.div_sel)
      DIV_XY:  begin div_a = x_r; div_b = y_r; end
      DIV_NG:  begin div_a = n_r; div_b = x_r; end
      default: begin div_a = d_r; div_b = x_r; end
    endcase
  end

  rau_div #(.XW(XW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.nd_en) begin
      n_r <= flip ? -nc : nc;
      d_r <= flip ? -dc : dc;
    end
    if (cmd.gcd_init) begin
      x_r <= n_r;
      y_r <= d_r;
    end else if (cmd.gcd_step) begin
      x_r <= y_r;
      y_r <= rem;
    end
    if (cmd.zero_res) begin
      rn_r <= '0;
      rd_r <= '0;
    end else begin
      if (cmd.rn_en) rn_r <= quo;
      if (cmd.rd_en) rd_r <= quo;
    end
    if (cmd.save_a) begin
      an_red_r <= rn_r;
      ad_red_r <= rd_r;
    end
  end

  always_comb begin
    case (cmd.func)
      FN_EQ:   cmp = (an_red_r == rn_r) && (ad_red_r == rd_r);
      FN_GT:   cmp = lhs_r > rhs_r;
      FN_LT:   cmp = lhs_r < rhs_r;
      FN_GE:   cmp = lhs_r >= rhs_r;
      FN_LE:   cmp = lhs_r <= rhs_r;
      default: cmp = 1'b0;
    endcase
  end

  assign res_num = (cmd.func inside {[FN_ADD:FN_DIV]}) ? RES_W'(rn_r) : '0;
  assign res_den = (cmd.func inside {[FN_ADD:FN_DIV]}) ? RES_W'(rd_r) : '0;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= OUT_W'({cmd.err, cmp, res_den, res_num});
    end
  end

  assign sts.d_zero   = (d_r == '0);
  assign sts.y_zero   = (y_r == '0);
  assign sts.div_done = div_done;
  assign out_data     = out_r;

endmodule
`default_nettype wire

>>> hw/rtl/rau_ctrl.sv
// controller state machine sequencing products, gcd loop, divisions and result hand-off
`default_nettype none
module rau_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [rau_pkg::FUNC_W-1:0] in_func,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output rau_pkg::cmd_t              cmd,
  input  rau_pkg::sts_t              sts
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL0  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_MUL3  = 4'd4;
  localparam logic [3:0] S_DISP  = 4'd5;
  localparam logic [3:0] S_RCHK  = 4'd6;
  localparam logic [3:0] S_GTEST = 4'd7;
  localparam logic [3:0] S_WXY   = 4'd8;
  localparam logic [3:0] S_WNG   = 4'd9;
  localparam logic [3:0] S_WDG   = 4'd10;
  localparam logic [3:0] S_RDONE = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]        state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic              pass_b_r, pass_b_nxt;
  logic              err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    func_nxt   = func_r;
    pass_b_nxt = pass_b_r;
    err_nxt    = err_r;
    cmd        = '0;
    cmd.func   = func_r;
    cmd.err    = err_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          func_nxt  = in_func;
          err_nxt   = 1'b0;
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_LHS; state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_RHS; state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DD; state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_NN; state_nxt = S_DISP;
      end
      S_DISP: begin
        pass_b_nxt = 1'b0;
        if (func_r inside {[FN_ADD:FN_DIV]}) begin
          cmd.nd_en = 1'b1; cmd.nd_sel = ND_ARITH; state_nxt = S_RCHK;
        end else if (func_r == FN_EQ) begin
          cmd.nd_en = 1'b1; cmd.nd_sel = ND_OPA; state_nxt = S_RCHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RCHK: begin
        if (sts.d_zero) begin
          cmd.zero_res = 1'b1;
          err_nxt      = (func_r inside {[FN_ADD:FN_DIV]});
          state_nxt    = S_RDONE;
        end else begin
          cmd.gcd_init = 1'b1;
          state_nxt    = S_GTEST;
        end
      end
      S_GTEST: begin
        cmd.div_start = 1'b1;
        if (sts.y_zero) begin
          cmd.div_sel = DIV_NG; state_nxt = S_WNG;
        end else begin
          cmd.div_sel = DIV_XY; state_nxt = S_WXY;
        end
      end
      S_WXY: begin
        cmd.div_sel = DIV_XY;
        if (sts.div_done) begin
          cmd.gcd_step = 1'b1; state_nxt = S_GTEST;
        end
      end
      S_WNG: begin
        cmd.div_sel = DIV_NG;
        if (sts.div_done) begin
          cmd.rn_en     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_DG;
          state_nxt     = S_WDG;
        end
      end
      S_WDG: begin
        cmd.div_sel = DIV_DG;
        if (sts.div_done) begin
          cmd.rd_en = 1'b1; state_nxt = S_RDONE;
        end
      end
      S_RDONE: begin
        if ((func_r == FN_EQ) && !pass_b_r) begin
          cmd.save_a = 1'b1;
          cmd.nd_en  = 1'b1;
          cmd.nd_sel = ND_OPB;
          pass_b_nxt = 1'b1;
          state_nxt  = S_RCHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      func_r      <= '0;
      pass_b_r    <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      func_r      <= func_nxt;
      pass_b_r    <= pass_b_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // result register is only overwritten once the previous result has gone
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result overwritten while pending");

  // divider completions only arrive while waiting on one
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_WXY || state_r == S_WNG || state_r == S_WDG))
    else $error("unexpected divider completion");

  // error only raised for arithmetic requests
  a_err_arith: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (func_r == FN_ADD || func_r == FN_SUB || func_r == FN_MUL || func_r == FN_DIV))
    else $error("error flag on comparison");

  // gcd starts only from a nonzero denominator
  a_gcd_nz: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gcd_init |=> !sts.y_zero)
    else $error("gcd started with zero denominator");

endmodule
`default_nettype wire

>>> hw/rtl/rational_arithmetic_unit.sv
// top level: rational add, subtract, multiply, divide and compare with gcd reduction
//
//  channel | direction | tdata fields (low bit up)
//  in_     | slave     | func[3:0] a_num[19:4] a_den[35:20] b_num[51:36] b_den[67:52]
//  out_    | master    | res_num[32:0] res_den[65:33] compare_true[66] div_error[67]
//
// one request at a time; in_tready is high only while idle
// comparisons: four products and the dispatch state, then the result is loaded
// once the output register is free; arithmetic and equality also run the gcd loop,
// one division per remainder step of the shared divider, then two more divisions
// of numerator and denominator by the gcd (equality reduces each operand in turn)
// a finished result waits in the output register while the next request is taken
// synchronous active-low reset clears control state only
`default_nettype none
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [rau_pkg::IN_W-1:0]  in_tdata,   // func, a_num, a_den, b_num, b_den
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [rau_pkg::OUT_W-1:0] out_tdata   // res_num, res_den, compare_true, div_error
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tdata[FUNC_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rau_dp #(.W(OPERAND_WIDTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_tdata),
    .sts      (sts),
    .out_data (out_tdata)
  );

endmodule
`default_nettype wire

>>> test/rational_arithmetic_unit_test.sv
// self-checking testbench for the rational arithmetic unit
`default_nettype none
module rational_arithmetic_unit_test;
  import rau_pkg::*;

  typedef struct {
    logic [RES_W-1:0] res_num;
    logic [RES_W-1:0] res_den;
    logic             compare_true;
    logic             div_error;
  } fraction_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;   // func, a_num, a_den, b_num, b_den
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;  // res_num, res_den, compare_true, div_error

  fraction_result_t  pending_results[$];
  int                mismatches;
  int                results_seen;
  int                requests_sent;
  longint            cycle_count;

  rational_arithmetic_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint euclid_gcd(longint x, longint y);
    longint r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic bit reduce_fraction(longint n, longint d, output longint rn,
                                         output longint rd);
    longint g;
    if (d == 0) begin
      rn = 0;
      rd = 0;
      return 1'b0;
    end
    if (n > 0 && d < 0) begin
      n = -n;
      d = -d;
    end
    g = euclid_gcd(n, d);
    rn = n / g;
    rd = d / g;
    return 1'b1;
  endfunction

  function automatic fraction_result_t predict_fraction(logic [3:0] func,
      logic signed [15:0] an16, logic signed [15:0] ad16,
      logic signed [15:0] bn16, logic signed [15:0] bd16);
    fraction_result_t r;
    longint an, ad, bn, bd, lhs, rhs, n, d, rn, rd, xn, xd, yn, yd;
    bit arith;
    an = an16; ad = ad16; bn = bn16; bd = bd16;
    lhs = an * bd;
    rhs = ad * bn;
    n = 0; d = 0; rn = 0; rd = 0;
    arith = 1'b0;
    r.compare_true = 1'b0;
    r.div_error = 1'b0;
    case (func)
      FN_ADD: begin n = lhs + rhs; d = ad * bd; arith = 1'b1; end
      FN_SUB: begin n = lhs - rhs; d = ad * bd; arith = 1'b1; end
      FN_MUL: begin n = an * bn; d = ad * bd; arith = 1'b1; end
      FN_DIV: begin n = lhs; d = rhs; arith = 1'b1; end
      FN_EQ: begin
        void'(reduce_fraction(an, ad, xn, xd));
        void'(reduce_fraction(bn, bd, yn, yd));
        r.compare_true = (xn == yn) && (xd == yd);
      end
      FN_GT: r.compare_true = lhs > rhs;
      FN_LT: r.compare_true = lhs < rhs;
      FN_GE: r.compare_true = lhs >= rhs;
      FN_LE: r.compare_true = lhs <= rhs;
      default: ;
    endcase
    if (arith) r.div_error = !reduce_fraction(n, d, rn, rd);
    r.res_num = rn[RES_W-1:0];
    r.res_den = rd[RES_W-1:0];
    return r;
  endfunction

  task automatic send_request(logic [3:0] func, logic [15:0] an, logic [15:0] ad,
                              logic [15:0] bn, logic [15:0] bd);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_results.push_back(predict_fraction(func, an, ad, bn, bd));
    in_tdata  <= {4'b0, bd, bn, ad, an, func};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  // result side stall and compare
  initial begin
    fraction_result_t exp_r;
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[32:0] !== exp_r.res_num || out_tdata[65:33] !== exp_r.res_den ||
            out_tdata[66] !== exp_r.compare_true || out_tdata[67] !== exp_r.div_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected num %h den %h cmp %b err %b, got %h",
                     exp_r.res_num, exp_r.res_den, exp_r.compare_true,
                     exp_r.div_error, out_tdata[67:0]);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 64'd20000000) begin
        $display("timeout with %0d results pending", pending_results.size());
        $display("rational_arithmetic_unit_test: errors");
        $finish;
      end
    end
  end

  function automatic logic [15:0] random_operand();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 20)) - 10);
      3: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    logic [15:0] vals[6];
    vals = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h8001};
    for (int i = 0; i < 9; i++)
      send_request(4'(i), vals[i % 6], vals[(i + 1) % 6], vals[(i + 2) % 6],
                   vals[(i + 4) % 6]);
    send_request(FN_EQ, 16'd3, 16'd0, 16'd5, 16'd0);
    send_request(FN_EQ, 16'd2, 16'd4, 16'hffff, 16'hfffe);
    send_request(FN_DIV, 16'd3, 16'd4, 16'd0, 16'd7);
    send_request(FN_ADD, 16'd1, 16'd0, 16'd1, 16'd2);
    send_request(FN_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(FN_SUB, 16'h7fff, 16'hffff, 16'h8000, 16'h0001);
    send_request(FN_ADD, 16'd5, 16'hfffd, 16'd0, 16'd1);
    send_request(4'd9, 16'd1, 16'd2, 16'd3, 16'd4);
    send_request(4'd15, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_request(FN_GE, 16'd1, 16'd2, 16'd2, 16'd4);
    send_request(FN_LE, 16'd1, 16'd2, 16'd2, 16'd4);
  endtask

  task automatic test_random_requests(int count);
    logic [3:0] func;
    for (int i = 0; i < count; i++) begin
      func = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
      send_request(func, random_operand(), random_operand(), random_operand(),
                   random_operand());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    mismatches = 0;
    results_seen = 0;
    requests_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_random_requests(930);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d requests sent covering all operations, extremes and zero denominators",
             requests_sent);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("rational_arithmetic_unit_test: clean");
    end else begin
      $display("rational_arithmetic_unit_test: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
hw/rtl/rau_pkg.sv
hw/rtl/rau_div.sv
hw/rtl/rau_dp.sv
hw/rtl/rau_ctrl.sv
hw/rtl/rational_arithmetic_unit.sv
test/rational_arithmetic_unit_test.sv
